### src/vpc_pkg.sv
package vpc_pkg;

	localparam int FRAC_BITS     = 16;
	localparam int MAX_DIMENSION = 4096;

	// clip values, viewport products and scaled numerators
	localparam int CW        = 50;
	localparam int TW        = 66;
	localparam int NW        = 76;
	localparam int DIV_STEPS = 32;
	localparam int LANES     = 3;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_POINT = 1'b1;

	typedef enum logic [2:0] {
		REG_VIEWPORT_LEFT,
		REG_VIEWPORT_TOP,
		REG_VIEWPORT_WIDTH,
		REG_VIEWPORT_HEIGHT,
		REG_SCISSOR_LEFT,
		REG_SCISSOR_TOP,
		REG_SCISSOR_WIDTH,
		REG_SCISSOR_HEIGHT
	} cfg_reg_t;

	typedef struct packed {
		logic              req_type;
		logic [3:0]        coeff_index;
		logic signed [31:0] coeff_value;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} req_t;

	typedef struct packed {
		logic              rejected;
		logic signed [31:0] pixel_x_milli;
		logic signed [31:0] pixel_y_milli;
		logic signed [31:0] depth_micro;
		logic [6:0]        clip_bits;
	} rsp_t;

endpackage

### src/vertex_project_clip_codes.sv
// throughput: one word per cycle while the output is empty or its result word is taken;
// six arithmetic stages, the divider entry register, a 32-step restoring divider
// with one quotient bit per stage for each of x, y and depth, then the output register
// the whole pipeline advances together and holds while the result word is not taken
// reset clears the transform table, sets the viewport and scissor registers to their
// defaults and empties the pipeline
module vertex_project_clip_codes (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  vpc_pkg::req_t              req,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output vpc_pkg::rsp_t              rsp,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  vpc_pkg::cfg_reg_t          cfg_index,
	input  logic [12:0]                cfg_data
);

	localparam int CW = vpc_pkg::CW;
	localparam int TW = vpc_pkg::TW;
	localparam int NW = vpc_pkg::NW;
	localparam int DS = vpc_pkg::DIV_STEPS;
	localparam int NL = vpc_pkg::LANES;

	logic en;
	logic take;

	logic [11:0] vl_q, vt_q, sl_q, st_q;
	logic [12:0] vw_q, vh_q, sw_q, sh_q;
	logic signed [31:0] tbl_q [16];

	assign en        = !rsp_valid || rsp_ready;
	assign req_ready = en;
	assign take      = req_valid && en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vl_q <= '0;
			vt_q <= '0;
			sl_q <= '0;
			st_q <= '0;
			vw_q <= 13'(vpc_pkg::MAX_DIMENSION);
			vh_q <= 13'(vpc_pkg::MAX_DIMENSION);
			sw_q <= 13'(vpc_pkg::MAX_DIMENSION);
			sh_q <= 13'(vpc_pkg::MAX_DIMENSION);
		end else if (cfg_valid) begin
			case (cfg_index)
				vpc_pkg::REG_VIEWPORT_LEFT:   vl_q <= cfg_data[11:0];
				vpc_pkg::REG_VIEWPORT_TOP:    vt_q <= cfg_data[11:0];
				vpc_pkg::REG_VIEWPORT_WIDTH:  vw_q <= cfg_data;
				vpc_pkg::REG_VIEWPORT_HEIGHT: vh_q <= cfg_data;
				vpc_pkg::REG_SCISSOR_LEFT:    sl_q <= cfg_data[11:0];
				vpc_pkg::REG_SCISSOR_TOP:     st_q <= cfg_data[11:0];
				vpc_pkg::REG_SCISSOR_WIDTH:   sw_q <= cfg_data;
				vpc_pkg::REG_SCISSOR_HEIGHT:  sh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) tbl_q[i] <= '0;
		end else if (take && req.req_type == vpc_pkg::REQ_LOAD) begin
			tbl_q[req.coeff_index] <= req.coeff_value;
		end
	end

	// control: valid bits per stage
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic dv_v_s [DS+1];
	logic v_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			for (int j = 0; j <= DS; j++) dv_v_s[j] <= 1'b0;
			v_out_q <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			dv_v_s[0] <= v_s6;
			for (int j = 0; j < DS; j++) dv_v_s[j+1] <= dv_v_s[j];
			v_out_q <= dv_v_s[DS];
		end
	end

	// stage 1: coefficient products
	logic signed [31:0] pt_c [3];
	logic signed [63:0] prod_s1 [4][3];
	logic signed [31:0] tr_s1 [4];
	logic pt_s1;

	assign pt_c[0] = req.point_x;
	assign pt_c[1] = req.point_y;
	assign pt_c[2] = req.point_z;

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s1 <= req.req_type;
			for (int r = 0; r < 4; r++) begin
				tr_s1[r] <= tbl_q[12+r];
				for (int c = 0; c < 3; c++) prod_s1[r][c] <= tbl_q[c*4+r] * pt_c[c];
			end
		end
	end

	// stage 2: clip coordinates
	logic signed [CW-1:0] clip_s2 [4];
	logic pt_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s2 <= pt_s1;
			for (int r = 0; r < 4; r++) begin
				clip_s2[r] <= CW'(tr_s1[r]) + CW'(prod_s1[r][0] >>> vpc_pkg::FRAC_BITS)
					+ CW'(prod_s1[r][1] >>> vpc_pkg::FRAC_BITS)
					+ CW'(prod_s1[r][2] >>> vpc_pkg::FRAC_BITS);
			end
		end
	end

	// stage 3: viewport offsets and frustum codes
	logic signed [CW:0] cxw_s3, wmy_s3;
	logic signed [CW-1:0] w_s3, cz_s3;
	logic [5:0] flags_s3;
	logic wpos_s3, pt_s3;
	logic signed [CW:0] cx_e, cy_e, w_e;

	assign cx_e = (CW+1)'(clip_s2[0]);
	assign cy_e = (CW+1)'(clip_s2[1]);
	assign w_e  = (CW+1)'(clip_s2[3]);

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s3       <= pt_s2;
			w_s3        <= clip_s2[3];
			cz_s3       <= clip_s2[2];
			wpos_s3     <= clip_s2[3] > 0;
			cxw_s3      <= cx_e + w_e;
			wmy_s3      <= w_e - cy_e;
			flags_s3[0] <= cx_e < -w_e;
			flags_s3[1] <= cx_e > w_e;
			flags_s3[2] <= cy_e > w_e;
			flags_s3[3] <= cy_e < -w_e;
			flags_s3[4] <= clip_s2[2] < 0;
			flags_s3[5] <= clip_s2[2] > clip_s2[3];
		end
	end

	// stage 4: viewport products, depth scale
	logic signed [TW-1:0] pa_s4, pb_s4, pc_s4, pd_s4;
	logic signed [NW-1:0] nz_s4;
	logic signed [CW-1:0] w_s4;
	logic [5:0] flags_s4;
	logic wpos_s4, pt_s4;
	logic signed [NW-1:0] cz_e;

	assign cz_e = NW'(cz_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s4    <= pt_s3;
			w_s4     <= w_s3;
			wpos_s4  <= wpos_s3;
			flags_s4 <= flags_s3;
			pa_s4    <= $signed({1'b0, vl_q}) * w_s3;
			pb_s4    <= $signed({1'b0, vw_q}) * cxw_s3;
			pc_s4    <= $signed({1'b0, vt_q}) * w_s3;
			pd_s4    <= $signed({1'b0, vh_q}) * wmy_s3;
			nz_s4    <= (cz_e <<< 20) - (cz_e <<< 16) + (cz_e <<< 14) + (cz_e <<< 9)
				+ (cz_e <<< 6);
		end
	end

	// stage 5: half-unit sums
	logic signed [TW-1:0] tx_s5, ty_s5;
	logic signed [NW-1:0] nz_s5;
	logic signed [CW-1:0] w_s5;
	logic [5:0] flags_s5;
	logic wpos_s5, pt_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s5    <= pt_s4;
			w_s5     <= w_s4;
			wpos_s5  <= wpos_s4;
			flags_s5 <= flags_s4;
			nz_s5    <= nz_s4;
			tx_s5    <= (pa_s4 <<< 1) + pb_s4;
			ty_s5    <= (pc_s4 <<< 1) + pd_s4;
		end
	end

	// stage 6: scale to millipixels
	logic signed [NW-1:0] n_s6 [NL];
	logic signed [CW-1:0] w_s6;
	logic [5:0] flags_s6;
	logic wpos_s6, pt_s6;
	logic signed [NW-1:0] tx_e, ty_e;

	assign tx_e = NW'(tx_s5);
	assign ty_e = NW'(ty_s5);

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s6    <= pt_s5;
			w_s6     <= w_s5;
			wpos_s6  <= wpos_s5;
			flags_s6 <= flags_s5;
			n_s6[0]  <= (tx_e <<< 9) - (tx_e <<< 3) - (tx_e <<< 2);
			n_s6[1]  <= (ty_e <<< 9) - (ty_e <<< 3) - (ty_e <<< 2);
			n_s6[2]  <= nz_s5;
		end
	end

	// divider entry: magnitude, early overflow, initial remainder
	logic [CW-1:0] dv_w_s [DS+1];
	logic [5:0] dv_flags_s [DS+1];
	logic dv_wpos_s [DS+1];
	logic dv_pt_s [DS+1];
	logic [CW-1:0] dv_rem_s [DS+1][NL];
	logic [DS-1:0] dv_lo_s [DS+1][NL];
	logic [DS-1:0] dv_q_s [DS+1][NL];
	logic dv_neg_s [DS+1][NL];
	logic dv_ovf_s [DS+1][NL];
	logic [NW-1:0] mag [NL];

	always_comb begin
		for (int l = 0; l < NL; l++) mag[l] = n_s6[l][NW-1] ? NW'(-n_s6[l]) : NW'(n_s6[l]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_w_s[0]     <= CW'(w_s6);
			dv_flags_s[0] <= flags_s6;
			dv_wpos_s[0]  <= wpos_s6;
			dv_pt_s[0]    <= pt_s6;
			for (int l = 0; l < NL; l++) begin
				dv_neg_s[0][l] <= n_s6[l][NW-1];
				dv_ovf_s[0][l] <= CW'(mag[l][NW-1:DS]) >= CW'(w_s6);
				dv_rem_s[0][l] <= CW'(mag[l][NW-1:DS]);
				dv_lo_s[0][l]  <= mag[l][DS-1:0];
				dv_q_s[0][l]   <= '0;
			end
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar j = 0; j < DS; j++) begin : g_div
		logic [CW:0] t [NL];
		logic ge [NL];

		always_comb begin
			for (int l = 0; l < NL; l++) begin
				t[l]  = {dv_rem_s[j][l], dv_lo_s[j][l][DS-1]};
				ge[l] = t[l] >= {1'b0, dv_w_s[j]};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_w_s[j+1]     <= dv_w_s[j];
				dv_flags_s[j+1] <= dv_flags_s[j];
				dv_wpos_s[j+1]  <= dv_wpos_s[j];
				dv_pt_s[j+1]    <= dv_pt_s[j];
				for (int l = 0; l < NL; l++) begin
					dv_neg_s[j+1][l] <= dv_neg_s[j][l];
					dv_ovf_s[j+1][l] <= dv_ovf_s[j][l];
					dv_lo_s[j+1][l]  <= {dv_lo_s[j][l][DS-2:0], 1'b0};
					dv_q_s[j+1][l]   <= {dv_q_s[j][l][DS-2:0], ge[l]};
					dv_rem_s[j+1][l] <= ge[l] ? CW'(t[l] - {1'b0, dv_w_s[j]}) : CW'(t[l]);
				end
			end
		end
	end

	// rounding, range check, scissor
	logic [31:0] lim [NL];
	logic ovf [NL];
	logic rnd [NL];
	logic [32:0] rq [NL];
	logic [31:0] res [NL];
	logic rem_nz [NL];
	logic [31:0] k_l, k_t, k_r, k_b;
	logic scissor, reject;
	vpc_pkg::rsp_t rsp_d;

	assign k_l = 32'(sl_q) * 32'd1000;
	assign k_t = 32'(st_q) * 32'd1000;
	assign k_r = (32'(sl_q) + 32'(sw_q)) * 32'd1000;
	assign k_b = (32'(st_q) + 32'(sh_q)) * 32'd1000;

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			lim[l]    = dv_neg_s[DS][l] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			rem_nz[l] = dv_rem_s[DS][l] != '0;
			ovf[l]    = dv_ovf_s[DS][l] || dv_q_s[DS][l] > lim[l]
				|| (dv_q_s[DS][l] == lim[l] && rem_nz[l]);
			rnd[l]    = {dv_rem_s[DS][l], 1'b0} >= {1'b0, dv_w_s[DS]};
			rq[l]     = {1'b0, dv_q_s[DS][l]} + 33'(rnd[l]);
			res[l]    = dv_neg_s[DS][l] ? 32'(33'd0 - rq[l]) : rq[l][31:0];
		end
		scissor = dv_neg_s[DS][0] || dv_q_s[DS][0] < k_l
			|| dv_neg_s[DS][1] || dv_q_s[DS][1] < k_t
			|| (!dv_neg_s[DS][0] && (dv_q_s[DS][0] > k_r
				|| (dv_q_s[DS][0] == k_r && rem_nz[0])))
			|| (!dv_neg_s[DS][1] && (dv_q_s[DS][1] > k_b
				|| (dv_q_s[DS][1] == k_b && rem_nz[1])));
		reject = !dv_wpos_s[DS] || ovf[0] || ovf[1] || ovf[2];
		rsp_d = '0;
		if (dv_pt_s[DS] == vpc_pkg::REQ_POINT) begin
			if (reject) begin
				rsp_d.rejected = 1'b1;
			end else begin
				rsp_d.pixel_x_milli = res[0];
				rsp_d.pixel_y_milli = res[1];
				rsp_d.depth_micro   = res[2];
				rsp_d.clip_bits     = {scissor, dv_flags_s[DS]};
			end
		end
	end

	vpc_pkg::rsp_t rsp_q;

	always_ff @(posedge clk) begin
		if (en) rsp_q <= rsp_d;
	end

	assign rsp_valid = v_out_q;
	assign rsp       = rsp_q;

endmodule
